// ===== rtl/kmm_pkg.sv =====
// Shared constants, word types and scan control type for the k-mer merge block.
`timescale 1ns / 1ps
package kmm_pkg;

	localparam int NUM_SOURCES = 16;
	localparam int KMER_BASES  = 24;

	localparam int KEY_W     = 2 * KMER_BASES;
	localparam int SRC_W     = $clog2(NUM_SOURCES);
	localparam int CNT_W     = $clog2(NUM_SOURCES + 1);
	localparam int IDX_W     = 4;
	localparam int OUT_KEY_W = 48;
	localparam int COUNT_W   = 31;
	localparam int MASK_W    = 16;
	localparam int CFG_W     = 7;

	typedef struct packed {
		logic [IDX_W-1:0]     source_index;
		logic [OUT_KEY_W-1:0] kmer_key;
		logic [COUNT_W-1:0]   record_count;
		logic                 source_end;
	} kmm_in_t;

	typedef struct packed {
		logic [OUT_KEY_W-1:0] merged_key;
		logic [MASK_W-1:0]    presence_mask;
		logic                 line_valid;
		logic [MASK_W-1:0]    refill_mask;
		logic                 all_done;
	} kmm_out_t;

	// scan control: clear and read-valid strobes, with the index and flag bits of one head read back from the RAM
	typedef struct packed {
		logic             clear;
		logic             vld;
		logic [SRC_W-1:0] idx;
		logic             head_valid;
		logic             head_present;
	} kmm_scan_ctl_t;

endpackage

// ===== rtl/kmm_head_ram.sv =====
// Single-port-write, single-port-read head key RAM with registered read data.
`timescale 1ns / 1ps
module kmm_head_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/kmm_scan.sv =====
// Running minimum over the heads read back one per cycle: best key, match set, present count.
`timescale 1ns / 1ps
module kmm_scan import kmm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kmm_scan_ctl_t          ctl,
	input  logic [KEY_W-1:0]       key,
	output logic [KEY_W-1:0]       best_key,
	output logic [NUM_SOURCES-1:0] match,
	output logic [CNT_W-1:0]       present_cnt
);

	logic                   any_q;
	logic [KEY_W-1:0]       best_q;
	logic [NUM_SOURCES-1:0] match_q;
	logic [CNT_W-1:0]       pcnt_q;
	logic [NUM_SOURCES-1:0] bit_oh;

	assign bit_oh = {{(NUM_SOURCES-1){1'b0}}, 1'b1} << ctl.idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (ctl.clear) begin
			any_q <= 1'b0;
		end else if (ctl.vld && ctl.head_valid) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld && ctl.head_valid) begin
			if (!any_q || key < best_q) begin
				best_q  <= key;
				match_q <= bit_oh;
				pcnt_q  <= CNT_W'(ctl.head_present);
			end else if (key == best_q) begin
				match_q <= match_q | bit_oh;
				pcnt_q  <= pcnt_q + CNT_W'(ctl.head_present);
			end
		end
	end

	assign best_key    = best_q;
	assign match       = match_q;
	assign present_cnt = pcnt_q;

endmodule

// ===== rtl/kmer_multiway_merge_presence.sv =====
// Top level: k-way merge of sorted k-mer streams with per-source presence reporting.
// Sequence: a word that leaves a source neither holding a head nor ended goes through ST_CHECK
//   back to ST_IDLE; an all-ended word goes through ST_CHECK to ST_FINISH for its done result;
//   a merge goes through ST_CHECK, ST_SCAN and ST_FINISH to the result showing on res_valid.
// Flow: a new word is taken only in ST_IDLE, after the last one is through; the head RAM scan
//   reads one source head per cycle through its single read port, and ST_FINISH waits on res_ready.
// Reset: arst_n clears all head flags, the ended flags, the FSM and res_valid at once, and
//   sets min_sources to 1; the head key RAM is not cleared, as a key is used only while its head flag is set.
`timescale 1ns / 1ps
module kmer_multiway_merge_presence import kmm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rec_valid,
	output logic             rec_ready,
	input  kmm_in_t          rec_data,
	output logic             res_valid,
	input  logic             res_ready,
	output kmm_out_t         res_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	// one-hot control states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]       min_src_q;
	logic [NUM_SOURCES-1:0] head_valid_q;
	logic [NUM_SOURCES-1:0] head_present_q;
	logic [NUM_SOURCES-1:0] ended_q;
	logic                   done_q;

	// scan address counter holds one extra code to mark the end of the reads
	logic [SRC_W:0]         rd_cnt_q;
	logic                   rd_en;
	logic                   rd_vld_s1;
	logic [SRC_W-1:0]       rd_idx_s1;
	logic [KEY_W-1:0]       rd_key;

	logic                   rec_acc;
	logic [SRC_W-1:0]       wr_idx;
	logic                   idx_ok;
	logic                   wr_key;
	logic [KEY_W-1:0]       key_in;

	kmm_scan_ctl_t          scan_ctl;
	logic [KEY_W-1:0]       best_key;
	logic [NUM_SOURCES-1:0] match;
	logic [CNT_W-1:0]       present_cnt;

	logic                   all_ready;
	logic                   any_head;
	logic                   res_free;
	logic                   res_load;
	logic [CFG_W-1:0]       need;
	kmm_out_t               res_next;

	assign cfg_ready = 1'b1;
	assign rec_ready = (state_q == ST_IDLE);
	assign rec_acc   = rec_valid && rec_ready;

	// incoming word decode; out-of-range index and ended sources leave the state alone
	assign idx_ok  = (int'(rec_data.source_index) < NUM_SOURCES);
	assign wr_idx  = SRC_W'(rec_data.source_index);
	assign key_in  = KEY_W'(rec_data.kmer_key);
	assign wr_key  = rec_acc && idx_ok && !ended_q[wr_idx] && !rec_data.source_end;

	// merge may run only once every source has a head or has ended
	assign all_ready = &(head_valid_q | ended_q);
	assign any_head  = |head_valid_q;

	assign res_free = !res_valid || res_ready;
	assign res_load = (state_q == ST_FINISH) && res_free;

	assign rd_en = (state_q == ST_SCAN) && (int'(rd_cnt_q) < NUM_SOURCES);

	kmm_head_ram #(
		.DEPTH(NUM_SOURCES),
		.WIDTH(KEY_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_key),
		.wr_addr(wr_idx),
		.wr_data(key_in),
		.rd_en  (rd_en),
		.rd_addr(rd_cnt_q[SRC_W-1:0]),
		.rd_data(rd_key)
	);

	always_comb begin
		scan_ctl.clear        = (state_q == ST_CHECK);
		scan_ctl.vld          = rd_vld_s1;
		scan_ctl.idx          = rd_idx_s1;
		scan_ctl.head_valid   = head_valid_q[rd_idx_s1];
		scan_ctl.head_present = head_present_q[rd_idx_s1];
	end

	kmm_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.key        (rd_key),
		.best_key   (best_key),
		.match      (match),
		.present_cnt(present_cnt)
	);

	// min_sources of zero behaves as one
	assign need = (min_src_q == '0) ? CFG_W'(1) : min_src_q;

	always_comb begin
		if (done_q) begin
			res_next = '0;
			res_next.all_done = 1'b1;
		end else begin
			res_next.merged_key    = OUT_KEY_W'(best_key);
			res_next.presence_mask = MASK_W'(match & head_present_q);
			res_next.line_valid    = (8'(present_cnt) >= 8'(need));
			res_next.refill_mask   = MASK_W'(match);
			res_next.all_done      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_src_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			min_src_q <= cfg_data;
		end
	end

	// control FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + (SRC_W+1)'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (rec_acc) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					rd_cnt_q <= '0;
					if (!all_ready) begin
						state_q <= ST_IDLE;
					end else if (!any_head) begin
						done_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						done_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// last head compared this cycle
					if (rd_vld_s1 && int'(rd_idx_s1) == NUM_SOURCES - 1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q[SRC_W-1:0];
	end

	// per-source flags: set on record, cleared on end mark or when consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q   <= '0;
			head_present_q <= '0;
			ended_q        <= '0;
		end else begin
			if (rec_acc && idx_ok && !ended_q[wr_idx]) begin
				if (rec_data.source_end) begin
					ended_q[wr_idx]        <= 1'b1;
					head_valid_q[wr_idx]   <= 1'b0;
					head_present_q[wr_idx] <= 1'b0;
				end else begin
					head_valid_q[wr_idx]   <= 1'b1;
					head_present_q[wr_idx] <= |rec_data.record_count;
				end
			end
			if (res_load && !done_q) begin
				head_valid_q   <= head_valid_q & ~match;
				head_present_q <= head_present_q & ~match;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_data <= res_next;
		end
	end

endmodule

// ===== rtl/kmm_checker.sv =====
// Port-level checker for the k-mer merge block, bound to the top level.
`timescale 1ns / 1ps
module kmm_checker import kmm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             rec_valid,
	input logic             rec_ready,
	input logic             res_valid,
	input logic             res_ready,
	input kmm_out_t         res_data
);

	// the block works one word at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready |=> !rec_ready)
		else $error("record taken right after another");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.all_done |-> res_data.merged_key == '0 &&
		res_data.presence_mask == '0 && !res_data.line_valid && res_data.refill_mask == '0)
		else $error("done result carries merge fields");

	a_present_in_refill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.presence_mask & ~res_data.refill_mask) == '0)
		else $error("present source not refilled");

endmodule

bind kmer_multiway_merge_presence kmm_checker u_kmm_checker (.*);
